// ----- hw/rtl/kft_pkg.sv -----
// Shared types and constants for the keyed flag table.
`default_nettype none

package kft_pkg;

    localparam int DEPTH_DEFAULT    = 16;
    localparam int KEY_BITS_DEFAULT = 16;

    localparam int ACTION_W      = 2;
    localparam int STATUS_W      = 2;
    localparam int CAP_W         = 5;
    localparam int COUNT_OUT_W   = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_SET    = 2'd2,
        ACT_QUERY  = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_DUP     = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_MOVE,
        S_WRITE,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/keyed_flag_table.sv -----
// Top level of the keyed flag table: scan, read-modify-write control, result register.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  s_      | s_valid s_ready s_action s_key s_flag_in | in
//  m_      | m_valid m_ready m_status m_flag_out      | out
//          | m_entry_count                           |
//  cfg     | cfg_we cfg_wdata (capacity)             | in
//
// Each item is served by a linear scan through the key RAM, one read per cycle
// with registered read data; a remove that hits then moves the last entry into
// the freed slot, and a full add skips the scan. Reset clears count and control
// only; RAM slots are never read above count. A stalled result holds in the output
// register while the next item is taken and scanned; its own result waits in S_DONE.
`default_nettype none

module keyed_flag_table #(
    parameter int DEPTH    = kft_pkg::DEPTH_DEFAULT,
    parameter int KEY_BITS = kft_pkg::KEY_BITS_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [kft_pkg::CAP_W-1:0]        cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [kft_pkg::ACTION_W-1:0]     s_action,
    input  wire logic [KEY_BITS-1:0]              s_key,
    input  wire logic                             s_flag_in,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [kft_pkg::STATUS_W-1:0]          m_status,
    output logic                                  m_flag_out,
    output logic [kft_pkg::COUNT_OUT_W-1:0]       m_entry_count
);

    import kft_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int WORD_W = KEY_BITS + 1;

    state_t               state_reg, state_next;
    logic [CAP_W-1:0]     cap_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    action_t              action_reg, action_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic                 flag_in_reg, flag_in_next;
    logic [CNT_W-1:0]     issue_idx_reg, issue_idx_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [ADDR_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic [ADDR_W-1:0]    slot_reg, slot_next;
    status_t              res_status_reg, res_status_next;
    logic                 res_flag_reg, res_flag_next;
    logic [ADDR_W-1:0]    wr_addr_reg, wr_addr_next;
    logic [WORD_W-1:0]    wr_data_reg, wr_data_next;
    logic                 m_valid_reg, m_valid_next;
    status_t              m_status_reg, m_status_next;
    logic                 m_flag_reg, m_flag_next;
    logic [CNT_W-1:0]     m_count_reg, m_count_next;

    logic                 ram_we, ram_re;
    logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
    logic [WORD_W-1:0]    ram_wdata, ram_rdata;

    logic                 issue;
    logic                 hit;
    logic                 last_cmp;
    logic                 full;
    logic [CNT_W-1:0]     count_m1;

    kft_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign count_m1 = count_reg - CNT_W'(1);
    assign issue    = (state_reg == S_SCAN) && (issue_idx_reg < count_reg);
    assign hit      = cmp_vld_reg && (ram_rdata[WORD_W-1:1] == key_reg);
    assign last_cmp = cmp_vld_reg && (CNT_W'(cmp_idx_reg) == count_m1);
    // Effective capacity is the smaller of the register and the built depth.
    assign full     = (CMP_W'(count_reg) >= CMP_W'(cap_reg)) ||
                      (CMP_W'(count_reg) >= CMP_W'(DEPTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cap_reg     <= CAP_RESET;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        action_reg     <= action_next;
        key_reg        <= key_next;
        flag_in_reg    <= flag_in_next;
        issue_idx_reg  <= issue_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_flag_reg   <= res_flag_next;
        wr_addr_reg    <= wr_addr_next;
        wr_data_reg    <= wr_data_next;
        m_status_reg   <= m_status_next;
        m_flag_reg     <= m_flag_next;
        m_count_reg    <= m_count_next;
    end

    // Next state and datapath registers.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        action_next     = action_reg;
        key_next        = key_reg;
        flag_in_next    = flag_in_reg;
        issue_idx_next  = issue_idx_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        slot_next       = slot_reg;
        res_status_next = res_status_reg;
        res_flag_next   = res_flag_reg;
        wr_addr_next    = wr_addr_reg;
        wr_data_next    = wr_data_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_flag_next     = m_flag_reg;
        m_count_next    = m_count_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    action_next    = action_t'(s_action);
                    key_next       = s_key;
                    flag_in_next   = s_flag_in;
                    issue_idx_next = '0;
                    res_flag_next  = 1'b0;
                    if (action_t'(s_action) == ACT_ADD && full) begin
                        res_status_next = ST_FULL;
                        state_next      = S_DONE;
                    end else if (count_reg == '0) begin
                        if (action_t'(s_action) == ACT_ADD) begin
                            wr_addr_next    = '0;
                            wr_data_next    = {s_key, 1'b0};
                            res_status_next = ST_OK;
                            state_next      = S_WRITE;
                        end else begin
                            res_status_next = ST_MISSING;
                            state_next      = S_DONE;
                        end
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    slot_next       = cmp_idx_reg;
                    res_status_next = ST_OK;
                    case (action_reg)
                        ACT_ADD: begin
                            res_status_next = ST_DUP;
                            state_next      = S_DONE;
                        end
                        ACT_REMOVE: begin
                            state_next = S_LAST;
                        end
                        ACT_SET: begin
                            wr_addr_next = cmp_idx_reg;
                            wr_data_next = {key_reg, flag_in_reg};
                            state_next   = S_WRITE;
                        end
                        default: begin
                            res_flag_next = ram_rdata[0];
                            state_next    = S_DONE;
                        end
                    endcase
                end else if (last_cmp) begin
                    if (action_reg == ACT_ADD) begin
                        wr_addr_next    = count_reg[ADDR_W-1:0];
                        wr_data_next    = {key_reg, 1'b0};
                        res_status_next = ST_OK;
                        state_next      = S_WRITE;
                    end else begin
                        res_status_next = ST_MISSING;
                        state_next      = S_DONE;
                    end
                end else if (issue) begin
                    issue_idx_next = issue_idx_reg + CNT_W'(1);
                    cmp_vld_next   = 1'b1;
                    cmp_idx_next   = issue_idx_reg[ADDR_W-1:0];
                end
            end
            S_LAST: begin
                state_next = S_MOVE;
            end
            S_MOVE: begin
                count_next = count_m1;
                state_next = S_DONE;
            end
            S_WRITE: begin
                if (action_reg == ACT_ADD) begin
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_flag_next   = res_flag_reg;
                    m_count_next  = count_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // RAM port and handshake outputs.
    always_comb begin
        s_ready   = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = issue_idx_reg[ADDR_W-1:0];
        ram_we    = 1'b0;
        ram_waddr = wr_addr_reg;
        ram_wdata = wr_data_reg;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_SCAN: begin
                ram_re = issue;
            end
            S_LAST: begin
                // fetch the last entry to fill the freed slot
                ram_re    = 1'b1;
                ram_raddr = count_m1[ADDR_W-1:0];
            end
            S_MOVE: begin
                ram_we    = 1'b1;
                ram_waddr = slot_reg;
                ram_wdata = ram_rdata;
            end
            S_WRITE: begin
                ram_we = 1'b1;
            end
            S_DONE: begin
                s_ready = 1'b0;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_flag_out    = m_flag_reg;
    assign m_entry_count = COUNT_OUT_W'(m_count_reg);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(count_reg) <= CMP_W'(DEPTH))
        else $error("entry count above depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (count_reg == $past(count_reg)) ||
                           (count_reg == $past(count_reg) + CNT_W'(1)) ||
                           (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("entry count moved by more than one");

    a_count_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (count_reg != $past(count_reg))) |->
            ($past(state_reg) == S_WRITE || $past(state_reg) == S_MOVE))
        else $error("entry count changed outside a write-back");

    a_cmp_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_vld_reg |-> (state_reg == S_SCAN))
        else $error("compare pending outside the scan");

endmodule

`default_nettype wire

// ----- hw/rtl/kft_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module kft_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
